### rtl/bitmap_alloc_map_with_scan_macros.svh
// Assertion macros shared by the checker of the allocation bitmap.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef BITMAP_ALLOC_MAP_WITH_SCAN_MACROS_SVH
`define BITMAP_ALLOC_MAP_WITH_SCAN_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BMAP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BMAP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bmap_pkg.sv
// Shared types and constants of the allocation bitmap block.
// No dependencies; imported by the top level, bmap_scan and the testbench.
package bmap_pkg;

  localparam int FIELD_W = 13;
  localparam int IDX_W = 13;
  localparam int FOUND_W = 12;
  localparam int FIELD_RESET = 4096;
  // Fixed-point shift for the multiply-by-reciprocal word split.
  localparam int RECIP_SHIFT = 20;

  typedef enum logic [2:0] {
    REQ_SET        = 3'd0,
    REQ_CLEAR      = 3'd1,
    REQ_READ       = 3'd2,
    REQ_FIND_SET   = 3'd3,
    REQ_FIND_CLEAR = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOCATE,
    ST_ACCESS,
    ST_SCAN
  } state_t;

endpackage

### rtl/bmap_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the bitmap word store.
module bmap_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/bmap_scan.sv
// Finds the lowest matching bit of one bitmap word inside a bit window.
// Uses bmap_pkg; instantiated by the top level's search path.
module bmap_scan #(
  parameter int WORD_BITS = 64,
  parameter int PW = 6
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic                 want,
  input  logic [PW-1:0]        lo,
  input  logic                 rem_all,
  input  logic [PW-1:0]        rem_low,
  output logic                 hit,
  output logic [PW-1:0]        pos
);
  import bmap_pkg::*;

  logic [WORD_BITS-1:0] mask_lo;
  logic [WORD_BITS-1:0] mask_hi;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] lowbit;

  always_comb begin
    mask_lo = {WORD_BITS{1'b1}} << lo;
    mask_hi = rem_all ? {WORD_BITS{1'b1}}
                      : ((WORD_BITS'(1) << rem_low) - WORD_BITS'(1));
    cand    = (want ? word : ~word) & mask_lo & mask_hi;
    // Isolate the lowest set bit, then encode its one-hot position.
    lowbit  = cand & (~cand + WORD_BITS'(1));
    hit     = |cand;
    pos     = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lowbit[i]) begin
        pos = pos | PW'(i);
      end
    end
  end

endmodule

### rtl/bitmap_alloc_map_with_scan.sv
// Top level of the allocation bitmap with find-next-set / find-next-clear.
// Depends on bmap_pkg, bmap_ram and bmap_scan.
//
// Usage: a request transfer is taken on a rising edge where start is high
// and busy is low; req_type selects set, clear, read, find-next-set or
// find-next-clear, and bit_index gives the bit or the search start (a
// negative start searches from bit 0). Every request yields exactly one
// result transfer: done is high for one cycle with bit_value, found and
// found_index valid. The receiver cannot stall, so results are never held.
// Set, clear and read go through the split and memory read, the modify/write
// and the result register. A search goes through the split and then checks
// one bitmap word per cycle, read ahead on the memory read port, until a hit
// or the field limit. The next request may be taken at the edge that ends
// the done cycle. Requests whose index is out of range, searches that start
// at or past the field limit and unused codes report in the cycle right after
// acceptance.
// The field size register is written with cfg_wr_en / cfg_wr_data; the user
// must write it only while the block is idle, as the block does not enforce
// this. It bounds searches only, clamped to MAP_BITS. After reset the bitmap
// memory is swept to zero, one word per cycle, and busy stays high meanwhile.
module bitmap_alloc_map_with_scan #(
  parameter int MAP_BITS = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [bmap_pkg::FIELD_W-1:0]       cfg_wr_data,
  input  logic                               start,
  input  logic [2:0]                         req_type,
  input  logic signed [bmap_pkg::IDX_W-1:0]  bit_index,
  output logic                               busy,
  output logic                               done,
  output logic                               bit_value,
  output logic                               found,
  output logic [bmap_pkg::FOUND_W-1:0]       found_index
);
  import bmap_pkg::*;

  localparam int NWORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int PW = $clog2(WORD_BITS);
  localparam int LIM_W = $clog2(MAP_BITS + 1);
  localparam int RECIP = (1 << RECIP_SHIFT) / WORD_BITS + 1;
  localparam int JW = IDX_W - 1;

  // Control and request registers.
  state_t               state, state_next;
  logic [AW-1:0]        clr_cnt, clr_cnt_next;
  logic [2:0]           req, req_next;
  logic [JW-1:0]        j, j_next;
  logic [IDX_W-1:0]     q, q_next;
  logic [LIM_W-1:0]     limit, limit_next;
  logic [AW-1:0]        word_addr, word_addr_next;
  logic [PW-1:0]        bit_lo, bit_lo_next;
  logic [LIM_W-1:0]     base, base_next;
  logic                 first, first_next;
  logic [FIELD_W-1:0]   field_bits;

  // Result registers.
  logic                 done_next;
  logic                 bit_value_next;
  logic                 found_next;
  logic [FOUND_W-1:0]   found_index_next;

  // Memory port signals.
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // Combinational helpers.
  logic [JW-1:0]        acc_j;
  logic [31:0]          lim_full;
  logic [31:0]          recip_prod;
  logic [31:0]          q_times_w;
  logic [LIM_W-1:0]     rem;
  logic                 rem_all;
  logic                 scan_hit;
  logic [PW-1:0]        scan_pos;
  logic [LIM_W-1:0]     hit_idx;
  logic                 want;

  bmap_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NWORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The word window of a search: the low bound applies only to the first
  // word, the high bound comes from the distance to the field limit.
  assign rem     = limit - base;
  assign rem_all = 32'(rem) >= 32'(WORD_BITS);
  assign want    = (req == REQ_FIND_SET);
  assign hit_idx = base + LIM_W'(scan_pos);

  bmap_scan #(
    .WORD_BITS (WORD_BITS),
    .PW        (PW)
  ) u_scan (
    .word    (ram_rdata),
    .want    (want),
    .lo      (first ? bit_lo : PW'(0)),
    .rem_all (rem_all),
    .rem_low (PW'(rem)),
    .hit     (scan_hit),
    .pos     (scan_pos)
  );

  assign busy = (state != ST_IDLE);

  // Request decode, the word/bit split and the search sequence.
  always_comb begin
    state_next       = state;
    clr_cnt_next     = clr_cnt;
    req_next         = req;
    j_next           = j;
    q_next           = q;
    limit_next       = limit;
    word_addr_next   = word_addr;
    bit_lo_next      = bit_lo;
    base_next        = base;
    first_next       = first;
    done_next        = 1'b0;
    bit_value_next   = 1'b0;
    found_next       = 1'b0;
    found_index_next = '0;
    ram_we           = 1'b0;
    ram_waddr        = word_addr;
    ram_wdata        = ram_rdata;
    ram_raddr        = word_addr;

    // A negative index becomes a start at bit zero for searches.
    acc_j      = bit_index[IDX_W-1] ? '0 : bit_index[JW-1:0];
    lim_full   = (32'(field_bits) > 32'(MAP_BITS)) ? 32'(MAP_BITS) : 32'(field_bits);
    // Exact quotient by the word size for any index below 2**IDX_W.
    recip_prod = 32'(acc_j) * 32'(RECIP);
    q_times_w  = 32'(q) * 32'(WORD_BITS);

    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
        if (clr_cnt == AW'(NWORDS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_cnt_next = clr_cnt + AW'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          req_next   = req_type;
          j_next     = acc_j;
          q_next     = IDX_W'(recip_prod >> RECIP_SHIFT);
          limit_next = LIM_W'(lim_full);
          case (req_type)
            REQ_SET, REQ_CLEAR, REQ_READ: begin
              if (bit_index[IDX_W-1] || (32'(acc_j) >= 32'(MAP_BITS))) begin
                done_next = 1'b1;
              end else begin
                state_next = ST_LOCATE;
              end
            end
            REQ_FIND_SET, REQ_FIND_CLEAR: begin
              if (32'(acc_j) >= lim_full) begin
                done_next = 1'b1;
              end else begin
                state_next = ST_LOCATE;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_LOCATE: begin
        ram_raddr      = AW'(q);
        word_addr_next = AW'(q);
        bit_lo_next    = PW'(32'(j) - q_times_w);
        base_next      = LIM_W'(q_times_w);
        first_next     = 1'b1;
        if ((req == REQ_FIND_SET) || (req == REQ_FIND_CLEAR)) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        // Read data for the addressed word is on the memory output now.
        done_next  = 1'b1;
        state_next = ST_IDLE;
        if (req == REQ_READ) begin
          bit_value_next = ram_rdata[bit_lo];
        end else begin
          ram_we            = 1'b1;
          ram_waddr         = word_addr;
          ram_wdata         = ram_rdata;
          ram_wdata[bit_lo] = (req == REQ_SET);
        end
      end
      ST_SCAN: begin
        // The next word is read ahead so that one word is checked per cycle.
        ram_raddr = word_addr + AW'(1);
        if (scan_hit) begin
          done_next        = 1'b1;
          found_next       = 1'b1;
          found_index_next = FOUND_W'(hit_idx);
          state_next       = ST_IDLE;
        end else if (!rem_all || (32'(rem) == 32'(WORD_BITS))) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          base_next      = base + LIM_W'(WORD_BITS);
          word_addr_next = word_addr + AW'(1);
          first_next     = 1'b0;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      done       <= 1'b0;
      field_bits <= FIELD_W'(FIELD_RESET);
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      done    <= done_next;
      if (cfg_wr_en) begin
        field_bits <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req         <= req_next;
    j           <= j_next;
    q           <= q_next;
    limit       <= limit_next;
    word_addr   <= word_addr_next;
    bit_lo      <= bit_lo_next;
    base        <= base_next;
    first       <= first_next;
    bit_value   <= bit_value_next;
    found       <= found_next;
    found_index <= found_index_next;
  end

endmodule

### rtl/bmap_checker.sv
// Port-level checker for the allocation bitmap, bound to the top level.
// Depends on bitmap_alloc_map_with_scan_macros.svh and the top level's ports.
`include "bitmap_alloc_map_with_scan_macros.svh"

module bmap_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        bit_value,
  input logic        found,
  input logic [11:0] found_index
);

  // An accepted request is either still in progress or reported next cycle.
  `BMAP_ASSERT_NEXT(a_accept_progress, clk, rst, start && !busy, busy || done, "request lost")

  // A result always follows an accepted request or work in progress.
  `BMAP_ASSERT_NOW(a_done_cause, clk, rst, done, $past(busy) || $past(start), "stray result")

  // A failed or non-search result reports index zero.
  `BMAP_ASSERT_NOW(a_fail_index, clk, rst, done && !found, found_index == 12'd0, "index not zero")

  // A search hit never carries a read value.
  `BMAP_ASSERT_NOW(a_found_no_value, clk, rst, done && found, !bit_value, "value on search")

endmodule

bind bitmap_alloc_map_with_scan bmap_checker u_bmap_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .bit_value   (bit_value),
  .found       (found),
  .found_index (found_index)
);

### verif/testbench.sv
// Self-checking testbench for bitmap_alloc_map_with_scan, the allocation bitmap with scans.
// Depends on bmap_pkg and the block's RTL; it has its own prediction of the bitmap.
`timescale 1ns / 100ps

module testbench;
  import bmap_pkg::*;

  // Size of the bitmap at the block's default parameters.
  localparam int MAP_SIZE = 4096;
  // Worst case for one request: the scan of all 64 words, plus the split and
  // the read, plus a little slack.
  localparam int DRAIN_CYCLES = 80;
  // Watchdog limit on the length of the whole run.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int REPORT_LIMIT = 10;

  // Request codes that the block does not use. It must answer them with an
  // all-zero result and leave the bitmap alone.
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_MID = 3'd6;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  // A search start of -1 means "search from bit 0".
  localparam logic [IDX_W-1:0] FROM_BIT_ZERO = '1;
  // The most negative index, which is also the only value with just the sign bit set.
  localparam logic [IDX_W-1:0] MOST_NEGATIVE = 13'h1000;

  // One expected result. The request is kept alongside so that a mismatch report
  // can say what was asked for.
  typedef struct packed {
    logic [2:0]         req;
    logic [IDX_W-1:0]   idx;
    logic               bit_value;
    logic               found;
    logic [FOUND_W-1:0] found_index;
  } bmap_result_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_wr_en;
  logic [FIELD_W-1:0]  cfg_wr_data;
  logic                start;
  logic [2:0]          req_type;
  logic signed [IDX_W-1:0] bit_index;
  logic                busy;
  logic                done;
  logic                bit_value;
  logic                found;
  logic [FOUND_W-1:0]  found_index;

  // Our own copy of the bitmap and of the field size register.
  logic [MAP_SIZE-1:0] alloc_shadow;
  logic [FIELD_W-1:0]  field_size;

  // Results that the block still owes us, oldest first.
  bmap_result_t pending_results[$];

  int unsigned error_count = 0;
  int unsigned results_checked = 0;
  int unsigned requests_sent = 0;
  int unsigned field_settings = 0;
  int unsigned bulk_runs = 0;
  int unsigned cycle_count = 0;

  // Controls for the stimulus. The sender idles at random only while
  // idle_enabled is set. Many random indexes fall in a window that starts
  // at hot_base, so that sets, clears and searches keep meeting each other.
  bit          idle_enabled = 1'b0;
  int unsigned hot_base = 0;

  bitmap_alloc_map_with_scan DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .start       (start),
    .req_type    (req_type),
    .bit_index   (bit_index),
    .busy        (busy),
    .done        (done),
    .bit_value   (bit_value),
    .found       (found),
    .found_index (found_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the shadow bitmap and work out the result the block
  // must return for it. A negative index never touches the bitmap. Indexes
  // 0..4095 all lie inside the map, so only the sign decides whether a set,
  // clear or read does anything. The field size bounds searches only, and it
  // is clamped to the size of the map.
  function automatic bmap_result_t predict_request(input logic [2:0] rq,
                                                   input logic [IDX_W-1:0] idx);
    bmap_result_t res;
    logic         negative;
    int unsigned  limit;
    int unsigned  pos;
    res = '0;
    res.req = rq;
    res.idx = idx;
    negative = idx[IDX_W-1];
    case (rq)
      REQ_SET: begin
        if (!negative) alloc_shadow[idx[FOUND_W-1:0]] = 1'b1;
      end
      REQ_CLEAR: begin
        if (!negative) alloc_shadow[idx[FOUND_W-1:0]] = 1'b0;
      end
      REQ_READ: begin
        if (!negative) res.bit_value = alloc_shadow[idx[FOUND_W-1:0]];
      end
      REQ_FIND_SET, REQ_FIND_CLEAR: begin
        limit = (field_size > MAP_SIZE) ? MAP_SIZE : field_size;
        pos = negative ? 0 : idx;
        while (pos < limit && alloc_shadow[pos] != (rq == REQ_FIND_SET)) pos++;
        if (pos < limit) begin
          res.found = 1'b1;
          res.found_index = pos[FOUND_W-1:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Result checker and request tracker. Both sides are sampled at the rising
  // edge, before that edge's updates land. A result is checked before this
  // edge's request is queued, because a result that arrives at the same
  // edge belongs to an earlier request.
  always @(posedge clk) begin : result_check
    bmap_result_t want;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("[%0t] ERROR: result with none expected: bit_value=%0b found=%0b idx=%0d",
                     $realtime, bit_value, found, found_index);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (bit_value !== want.bit_value || found !== want.found ||
              found_index !== want.found_index) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $write("[%0t] MISMATCH req=%0d index=%0d field=%0d: ",
                     $realtime, want.req, $signed(want.idx), field_size);
              $display("expected bit_value=%0b found=%0b idx=%0d, got bit_value=%0b found=%0b idx=%0d",
                       want.bit_value, want.found, want.found_index,
                       bit_value, found, found_index);
            end
          end
        end
      end
      if (start && !busy) pending_results.push_back(predict_request(req_type, bit_index));
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[%0t] ERROR: watchdog expired after %0d cycles", $realtime, cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // The sender stays idle for some cycles. It drives junk on the request
  // fields, which the block must ignore while start is low.
  task automatic idle_sender(input int unsigned cycles);
    start <= 1'b0;
    req_type <= 3'($urandom);
    bit_index <= IDX_W'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Send one request and return at the edge where the transfer is taken.
  // start is left high. The next call either lowers it through idle_sender in
  // a later step, or keeps it high for a request sent back to back.
  task automatic send_request(input logic [2:0] rq, input logic [IDX_W-1:0] idx);
    if (idle_enabled && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 14));
    start <= 1'b1;
    req_type <= rq;
    bit_index <= idx;
    do @(posedge clk); while (busy);
    requests_sent++;
  endtask

  // Hold off the sender until every expected result has arrived and the
  // block reports idle.
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Write the field size register. The block is idle: the sender is drained
  // first, and after reset this waits out the sweep that clears the memory.
  task automatic write_field_size(input logic [FIELD_W-1:0] value);
    wait_for_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= FIELD_W'($urandom);
    field_size = value;
    field_settings++;
  endtask

  // Random index. Four in ten values fall in the hot window; the rest are anywhere in
  // the map, negative, or one of the boundary values.
  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned pos;
    case ($urandom_range(0, 9))
      0: return MOST_NEGATIVE | IDX_W'($urandom_range(0, MAP_SIZE - 1));
      1: begin
        case ($urandom_range(0, 5))
          0: return '0;
          1: return IDX_W'(MAP_SIZE - 1);
          2: return IDX_W'(63);
          3: return IDX_W'(64);
          4: return FROM_BIT_ZERO;
          default: return MOST_NEGATIVE;
        endcase
      end
      2, 3, 4, 5: begin
        pos = hot_base + $urandom_range(0, 191);
        return IDX_W'((pos > MAP_SIZE - 1) ? MAP_SIZE - 1 : pos);
      end
      default: return IDX_W'($urandom_range(0, MAP_SIZE - 1));
    endcase
  endfunction

  // Boundary values of both fields, every request code, and the obvious
  // special cases: out-of-map indexes, searches that start from -1, and
  // searches that fail on an empty or a full stretch of the map.
  task automatic test_directed_corners();
    send_request(REQ_READ, '0);
    send_request(REQ_FIND_SET, FROM_BIT_ZERO);   // all clear after reset: fails
    send_request(REQ_FIND_CLEAR, FROM_BIT_ZERO);
    send_request(REQ_SET, '0);
    send_request(REQ_SET, IDX_W'(MAP_SIZE - 1));
    send_request(REQ_SET, IDX_W'(2047));
    send_request(REQ_READ, IDX_W'(MAP_SIZE - 1));
    send_request(REQ_READ, '0);
    send_request(REQ_READ, FROM_BIT_ZERO);       // negative index reads as 0
    send_request(REQ_SET, FROM_BIT_ZERO);        // negative index changes nothing
    send_request(REQ_CLEAR, MOST_NEGATIVE);
    send_request(REQ_FIND_SET, MOST_NEGATIVE);   // any negative start means bit 0
    send_request(REQ_FIND_SET, IDX_W'(1));
    send_request(REQ_FIND_SET, IDX_W'(2048));
    send_request(REQ_FIND_SET, IDX_W'(MAP_SIZE - 1));
    send_request(REQ_FIND_CLEAR, IDX_W'(MAP_SIZE - 1)); // last bit set: fails
    send_request(REQ_FIND_CLEAR, '0);
    send_request(REQ_UNUSED_LO, IDX_W'(5));
    send_request(REQ_UNUSED_MID, FROM_BIT_ZERO);
    send_request(REQ_UNUSED_HI, IDX_W'(MAP_SIZE - 1));
    send_request(REQ_CLEAR, IDX_W'(2047));
    send_request(REQ_CLEAR, IDX_W'(MAP_SIZE - 1));
    send_request(REQ_READ, IDX_W'(MAP_SIZE - 1));
    send_request(REQ_CLEAR, '0);
    send_request(REQ_FIND_SET, FROM_BIT_ZERO);
  endtask

  // Field size corners. Zero empties the field, sizes past the map are
  // clamped to it, and word boundaries are tried at 64 and 65. For each size,
  // searches start at -1, just below the limit and at the limit or the map's last bit.
  task automatic test_field_limits();
    logic [FIELD_W-1:0] sizes [7];
    logic [IDX_W-1:0]   below_limit;
    logic [IDX_W-1:0]   at_limit;
    sizes = '{13'd0, 13'd1, 13'd64, 13'd65, 13'd4097, 13'h1FFF, 13'd4096};
    send_request(REQ_SET, IDX_W'(63));
    send_request(REQ_SET, IDX_W'(64));
    foreach (sizes[k]) begin
      write_field_size(sizes[k]);
      below_limit = (sizes[k] == 0) ? '0 :
                    (sizes[k] > MAP_SIZE) ? IDX_W'(MAP_SIZE - 1) : IDX_W'(sizes[k] - 1);
      at_limit = (sizes[k] > MAP_SIZE - 1) ? IDX_W'(MAP_SIZE - 1) : sizes[k];
      send_request(REQ_FIND_SET, FROM_BIT_ZERO);
      send_request(REQ_FIND_CLEAR, FROM_BIT_ZERO);
      send_request(REQ_FIND_CLEAR, below_limit);
      send_request(REQ_FIND_SET, at_limit);
    end
  endtask

  // One phase of random traffic at one field size. Besides single requests,
  // it sets or clears whole runs of bits. Dense and empty stretches are needed
  // for the searches to cross many words before they stop.
  task automatic test_random_traffic(input int unsigned count,
                                     input logic [FIELD_W-1:0] size,
                                     input bit with_idle);
    int unsigned first;
    int unsigned pick;
    int unsigned run_start;
    int unsigned run_len;
    logic [2:0]  run_op;
    logic [2:0]  rq;
    write_field_size(size);
    idle_enabled = with_idle;
    first = requests_sent;
    while (requests_sent - first < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        run_start = hot_base + $urandom_range(0, 127);
        run_len = $urandom_range(8, 150);
        run_op = ($urandom_range(0, 9) < 7) ? REQ_SET : REQ_CLEAR;
        bulk_runs++;
        for (int unsigned i = 0; i < run_len && run_start + i < MAP_SIZE; i++)
          send_request(run_op, IDX_W'(run_start + i));
      end else if (pick < 7 && with_idle) begin
        wait_for_results();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 28) rq = REQ_SET;
        else if (pick < 46) rq = REQ_CLEAR;
        else if (pick < 62) rq = REQ_READ;
        else if (pick < 79) rq = REQ_FIND_SET;
        else if (pick < 96) rq = REQ_FIND_CLEAR;
        else rq = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
        send_request(rq, pick_index());
      end
    end
    idle_enabled = 1'b0;
  endtask

  initial begin
    int unsigned settle;
    rst <= 1'b1;
    start <= 1'b0;
    req_type <= '0;
    bit_index <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    alloc_shadow = '0;
    field_size = FIELD_W'(FIELD_RESET);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_field_limits();

    // Random phases. Each phase uses its own field size and hot window. The
    // last phase runs without gaps on the sender side.
    hot_base = $urandom_range(0, MAP_SIZE - 256);
    test_random_traffic(225, 13'd4096, 1'b1);
    hot_base = $urandom_range(0, MAP_SIZE - 256);
    test_random_traffic(225, 13'h1FFF, 1'b1);
    hot_base = 0;
    test_random_traffic(225, FIELD_W'($urandom_range(1, 200)), 1'b1);
    hot_base = $urandom_range(0, MAP_SIZE - 256);
    test_random_traffic(225, FIELD_W'($urandom_range(1, MAP_SIZE)), 1'b1);
    hot_base = $urandom_range(MAP_SIZE - 512, MAP_SIZE - 128);
    test_random_traffic(225, FIELD_W'($urandom_range(MAP_SIZE + 1, 8191)), 1'b1);
    hot_base = $urandom_range(0, MAP_SIZE - 256);
    test_random_traffic(225, 13'd4096, 1'b0);

    // Wind down: wait for the last results, then give the block the time of
    // one full scan to show any result it should not produce.
    start <= 1'b0;
    settle = 0;
    while (pending_results.size() != 0 && settle < 10 * DRAIN_CYCLES) begin
      @(posedge clk);
      settle++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("[%0t] ERROR: %0d expected results never arrived",
               $realtime, pending_results.size());
      error_count += pending_results.size();
    end

    $display("Run: %0d requests sent, %0d results checked, %0d mismatches.",
             requests_sent, results_checked, error_count);
    $display("Covered %0d field sizes, including empty, clamped and word-boundary ones,",
             field_settings);
    $display("and %0d bulk runs of sets or clears.", bulk_runs);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
